[sv/tft_pkg.sv]
// ----------------------------------------------------------------------------
// tft_pkg
// shared constants for the top-k frequency tracker
// ----------------------------------------------------------------------------
package tft_pkg;
  localparam int ITEM_COUNT = 1024;
  localparam int K_MAX      = 16;
  localparam int COUNT_BITS = 32;
  localparam int ID_W       = $clog2(ITEM_COUNT);
  localparam int SLOT_W     = $clog2(K_MAX);
  localparam int FILL_W     = $clog2(K_MAX + 1);
  localparam logic [FILL_W-1:0] NOT_IN_HEAP = FILL_W'(K_MAX);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [FILL_W-1:0] K_RESET = FILL_W'(K_MAX);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [ID_W-1:0]       id_t;
endpackage

[sv/topk_frequency_tracker_unit.sv]
// ----------------------------------------------------------------------------
// topk_frequency_tracker_unit
// a read runs S_R0, S_R1; an add S_A0, S_A1/S_RT0 if needed, heap moves, S_F0, S_F1
// a level sunk runs S_N0 to S_N4, S_SW0 and S_SW1, a level risen skips S_N2
// throughput: one item at a time, busy high from accept to the done strobe
// the pace is set by one count table read per cycle during heap moves
// after reset a clearing pass sweeps all 1024 entries of the count and position tables
// the result strobe lasts one cycle and the receiver cannot stall it
// ----------------------------------------------------------------------------
module topk_frequency_tracker_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cfg_we_i,
  input  logic [4:0]                  cfg_data_i,
  input  logic                        req_type_i,
  input  logic [9:0]                  item_id_i,
  input  logic [3:0]                  slot_i,
  output logic                        done_o,
  output logic [9:0]                  item_out_o,
  output logic [31:0]                 count_out_o,
  output logic                        in_top_o,
  output logic [3:0]                  position_out_o,
  output logic [31:0]                 threshold_o,
  output logic [4:0]                  fill_o,
  output logic                        slot_empty_o
);
  import tft_pkg::*;

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_A0   = 5'd2;   // count/pos read
  localparam logic [4:0] S_A1   = 5'd3;   // decide
  localparam logic [4:0] S_RT0  = 5'd4;   // write root pos of new item
  localparam logic [4:0] S_N0   = 5'd5;   // node loop: read cur count
  localparam logic [4:0] S_N1   = 5'd6;
  localparam logic [4:0] S_N2   = 5'd7;   // take left, read right
  localparam logic [4:0] S_N3   = 5'd8;   // take right or parent
  localparam logic [4:0] S_N4   = 5'd9;   // compare
  localparam logic [4:0] S_SW0  = 5'd10;  // swap writes
  localparam logic [4:0] S_SW1  = 5'd11;
  localparam logic [4:0] S_F0   = 5'd12;  // final reads
  localparam logic [4:0] S_F1   = 5'd13;
  localparam logic [4:0] S_F2   = 5'd14;
  localparam logic [4:0] S_R0   = 5'd15;
  localparam logic [4:0] S_R1   = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  // tables
  count_t            cnt_mem [ITEM_COUNT];
  logic [FILL_W-1:0] pos_mem [ITEM_COUNT];
  id_t               heap_q  [K_MAX];

  logic              cnt_we, pos_we;
  id_t               cnt_wa, cnt_ra, pos_wa, pos_ra;
  count_t            cnt_wd, cnt_rd;
  logic [FILL_W-1:0] pos_wd, pos_rd;

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd <= cnt_mem[cnt_ra];
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd <= pos_mem[pos_ra];
  end

  logic [4:0]        st_q, st_d;
  logic [ID_W-1:0]   clr_q, clr_d;
  logic [FILL_W-1:0] fill_q, fill_d, k_q;
  id_t               id_q, id_d;
  count_t            cid_q, cid_d, cc_q, cc_d, cl_q, cl_d, cr_q, cr_d;
  logic [SLOT_W-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic              up_q, up_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic              emp_q, emp_d;
  count_t            thr_q, thr_d, oc_q, oc_d;
  logic [FILL_W-1:0] op_q, op_d;
  id_t               oi_q, oi_d;
  logic              hwe;
  logic [SLOT_W-1:0] hwa;
  id_t               hwd;
  logic              hwe2;
  logic [SLOT_W-1:0] hwa2;
  id_t               hwd2;

  logic [FILL_W-1:0] cap;
  logic [FILL_W:0]   lft, rgt, par;

  always_comb begin
    if (k_q == '0) cap = FILL_W'(1);
    else if (k_q > FILL_W'(K_MAX)) cap = FILL_W'(K_MAX);
    else cap = k_q;
    lft = {1'b0, cur_q, 1'b1};
    rgt = lft + 1'b1;
    par = (FILL_W+1)'((cur_q - 1'b1) >> 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= K_RESET;
    end else if (cfg_we_i) begin
      k_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hwe) heap_q[hwa] <= hwd;
    if (hwe2) heap_q[hwa2] <= hwd2;
  end

  always_comb begin
    st_d = st_q; clr_d = clr_q; fill_d = fill_q; id_d = id_q; cid_d = cid_q;
    cc_d = cc_q; cl_d = cl_q; cr_d = cr_q; cur_d = cur_q; tgt_d = tgt_q;
    up_d = up_q; rslot_d = rslot_q; emp_d = emp_q;
    thr_d = thr_q; oc_d = oc_q; op_d = op_q; oi_d = oi_q;
    cnt_we = 1'b0; cnt_wa = id_q; cnt_wd = cid_q; cnt_ra = id_q;
    pos_we = 1'b0; pos_wa = id_q; pos_wd = NOT_IN_HEAP; pos_ra = id_q;
    hwe = 1'b0; hwa = cur_q; hwd = id_q;
    hwe2 = 1'b0; hwa2 = tgt_q; hwd2 = id_q;
    unique case (st_q)
      S_CLR: begin
        cnt_we = 1'b1; cnt_wa = clr_q; cnt_wd = '0;
        pos_we = 1'b1; pos_wa = clr_q; pos_wd = NOT_IN_HEAP;
        clr_d = clr_q + 1'b1;
        if (clr_q == ID_W'(ITEM_COUNT - 1)) st_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          id_d = item_id_i; rslot_d = slot_i;
          cnt_ra = item_id_i; pos_ra = item_id_i;
          if (req_type_i) begin
            cnt_ra = heap_q[slot_i];
            st_d = S_R0;
          end else st_d = S_A0;
        end
      end
      S_A0: begin
        cid_d = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
        cnt_we = 1'b1; cnt_wd = cid_d;
        st_d = S_A1;
        cur_d = pos_rd[SLOT_W-1:0];
        if (pos_rd < fill_q) begin
          up_d = 1'b0; st_d = S_N0;
        end else begin
          pos_we = 1'b1; pos_wd = NOT_IN_HEAP;
          if (fill_q >= cap) begin
            cnt_ra = heap_q[0];
            st_d = S_A1;
          end else begin
            hwe = 1'b1; hwa = fill_q[SLOT_W-1:0];
            pos_we = 1'b1; pos_wd = fill_q;
            cur_d = fill_q[SLOT_W-1:0]; up_d = 1'b1;
            fill_d = fill_q + 1'b1;
            st_d = S_N0;
          end
        end
      end
      S_A1: begin
        if (fill_q != '0 && cnt_rd < cid_q) begin
          pos_we = 1'b1; pos_wa = heap_q[0]; pos_wd = NOT_IN_HEAP;
          hwe = 1'b1; hwa = '0;
          cur_d = '0; up_d = 1'b0;
          st_d = S_RT0;
        end else st_d = S_F0;
      end
      S_RT0: begin
        pos_we = 1'b1; pos_wd = '0;
        st_d = S_N0;
      end
      S_N0: begin
        cnt_ra = heap_q[cur_q];
        st_d = S_N1;
      end
      S_N1: begin
        cc_d = cnt_rd;
        if (up_q) begin
          if (cur_q == '0) st_d = S_F0;
          else begin
            cnt_ra = heap_q[par[SLOT_W-1:0]];
            st_d = S_N3;
          end
        end else if (lft >= (FILL_W+1)'(fill_q)) st_d = S_F0;
        else begin
          cnt_ra = heap_q[lft[SLOT_W-1:0]];
          st_d = S_N2;
        end
      end
      S_N2: begin
        cl_d = cnt_rd;
        cnt_ra = heap_q[rgt[SLOT_W-1:0]];
        st_d = S_N3;
      end
      S_N3: begin
        cr_d = cnt_rd;
        st_d = S_N4;
      end
      S_N4: begin
        st_d = S_F0;
        if (up_q) begin
          if (cc_q < cr_q) begin
            tgt_d = par[SLOT_W-1:0]; st_d = S_SW0;
          end
        end else if (rgt < (FILL_W+1)'(fill_q) && cr_q < cl_q) begin
          if (cr_q < cc_q) begin
            tgt_d = rgt[SLOT_W-1:0]; st_d = S_SW0;
          end
        end else if (cl_q < cc_q) begin
          tgt_d = lft[SLOT_W-1:0]; st_d = S_SW0;
        end
      end
      S_SW0: begin
        pos_we = 1'b1; pos_wa = heap_q[cur_q]; pos_wd = FILL_W'(tgt_q);
        hwe = 1'b1; hwa = cur_q; hwd = heap_q[tgt_q];
        hwe2 = 1'b1; hwa2 = tgt_q; hwd2 = heap_q[cur_q];
        st_d = S_SW1;
      end
      S_SW1: begin
        pos_we = 1'b1; pos_wa = heap_q[cur_q]; pos_wd = FILL_W'(cur_q);
        cur_d = tgt_q;
        st_d = S_N0;
      end
      S_F0: begin
        cnt_ra = heap_q[0];
        st_d = S_F1;
      end
      S_F1: begin
        thr_d = (fill_q == '0) ? '0 : cnt_rd;
        oi_d = id_q; oc_d = cid_q; op_d = pos_rd; emp_d = 1'b0;
        st_d = S_OUT;
      end
      S_R0: begin
        st_d = S_R1;
        cnt_ra = heap_q[0];
        oc_d = cnt_rd;
        emp_d = (FILL_W'(rslot_q) >= fill_q);
        oi_d = heap_q[rslot_q];
        op_d = FILL_W'(rslot_q);
      end
      S_R1: begin
        thr_d = (fill_q == '0) ? '0 : cnt_rd;
        st_d = S_OUT;
      end
      S_OUT: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_q <= '0; fill_q <= '0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d; cid_q <= cid_d; cc_q <= cc_d; cl_q <= cl_d; cr_q <= cr_d;
    cur_q <= cur_d; tgt_q <= tgt_d; up_q <= up_d;
    rslot_q <= rslot_d; emp_q <= emp_d; thr_q <= thr_d; oc_q <= oc_d;
    op_q <= op_d; oi_q <= oi_d;
  end

  logic top_w;
  assign top_w = !emp_q && (op_q < fill_q);
  assign busy = (st_q != S_IDLE);
  assign done_o = (st_q == S_OUT);
  assign item_out_o = emp_q ? '0 : oi_q;
  assign count_out_o = emp_q ? '0 : oc_q;
  assign in_top_o = top_w;
  assign position_out_o = top_w ? op_q[SLOT_W-1:0] : '0;
  assign threshold_o = thr_q;
  assign fill_o = fill_q;
  assign slot_empty_o = emp_q;

  a_fill_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(K_MAX)) else $error("fill over capacity");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q >= $past(fill_q)) else $error("fill shrank");
endmodule
